[rtl/srcf_pkg.sv]
package srcf_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HUMIDITY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAIN_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAIN_TOTAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT   = 3'd5;

	localparam logic [30:0] RST_MAX_TEMP       = 31'd2000;
	localparam logic [30:0] RST_MAX_HUMIDITY   = 31'd2000;
	localparam logic [30:0] RST_MAX_RAIN_RATE  = 31'd20000;
	localparam logic [30:0] RST_MAX_RAIN_TOTAL = 31'd20000;
	localparam logic [31:0] RST_REFRESH_TICKS  = 32'd3600000;
	localparam logic [7:0]  RST_REJECT_LIMIT   = 8'd18;

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [7:0] REJECTS_MAX = 8'hFF;

	typedef struct packed {
		logic               command;
		logic [1:0]         kind;
		logic [15:0]        sensor_id;
		logic signed [31:0] value;
	} sample_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic [15:0]        out_sensor_id;
		logic signed [31:0] out_value;
		logic               first_seen;
		logic               table_full;
	} result_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sensor;
		logic [31:0] value;
		logic [7:0]  rejects;
		logic [31:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIFF,
		ST_JUDGE,
		ST_MISS,
		ST_EMIT
	} state_t;

endpackage

[rtl/srcf_stream_if.sv]
interface srcf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sensor_reading_change_filter_unit.sv]
// measurement: a new key's result follows the scan of all filled entries and the miss state;
// a known key's result, if it passes, follows the scan up to its index and the diff and judge
// states; emit waits for a free output register; the key scan reads one entry per cycle
// tick: no result; ticks may arrive every cycle while idle; a new item is taken once the previous
// one has left the sequencer, even while its result still waits in the output register
// reset clears the fill count, the clock and the output valid; table contents need no clearing
module sensor_reading_change_filter_unit #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [srcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srcf_pkg::CFG_DATA_W-1:0] cfg_data,
	srcf_stream_if.sink                    sample,
	srcf_stream_if.source                  result
);
	import srcf_pkg::*;

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	// configuration registers
	logic [30:0] max_chg_q [4];
	logic [31:0] refresh_q;
	logic [7:0]  rej_limit_q;

	// control state
	state_t      state_q, state_d;
	logic [CW-1:0] fill_q;    // entries are never freed: index < fill means valid
	logic [CW-1:0] addr_q;    // next scan address
	logic        chk_s1;      // ent_q holds a freshly read entry to compare
	logic [AW-1:0] chk_idx_s1;
	logic [31:0] now_q;
	logic        out_valid_q;

	// datapath registers
	sample_t     item_q;
	entry_t      ent_q;
	logic [32:0] diff_q;
	logic [31:0] elapsed_q;
	logic        changed_q;
	logic        first_q;
	logic        full_q;
	result_t     out_q;

	// entry table
	entry_t      mem [ENTRIES];
	logic        mem_re;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t      mem_wdata;

	logic        accept;
	logic        meas_accept;
	logic        tick_accept;
	logic        out_take;
	logic        load_out;
	logic        issue;
	logic        hit_now;
	logic        room;
	logic [32:0] jump;
	logic        reasonable;
	logic        timed;
	logic        lenient;
	logic        pass;

	assign accept      = sample.valid && sample.ready;
	assign meas_accept = accept && (sample.data.command == CMD_MEASURE);
	assign tick_accept = accept && (sample.data.command == CMD_TICK);
	assign out_take    = result.valid && result.ready;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// scan compare on the registered read data
	assign issue   = addr_q < fill_q;
	assign hit_now = chk_s1 && (ent_q.kind == item_q.kind)
		&& (ent_q.sensor == item_q.sensor_id);
	assign room    = fill_q < CW'(ENTRIES);

	// decision on the hit entry, from the registered difference
	assign jump       = diff_q[32] ? (33'd0 - diff_q) : diff_q;
	assign reasonable = jump < {2'b00, max_chg_q[item_q.kind]};
	assign timed      = elapsed_q > refresh_q;
	assign lenient    = ent_q.rejects > rej_limit_q;
	assign pass       = (timed || changed_q) && (reasonable || lenient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = chk_idx_s1;
		mem_wdata    = ent_q;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid && (sample.data.command == CMD_MEASURE)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// stop reading on a hit so ent_q keeps the matching entry
				mem_re = issue && !hit_now;
				if (hit_now) begin
					state_d = ST_DIFF;
				end else if (!issue && !chk_s1) begin
					state_d = ST_MISS;
				end
			end
			ST_DIFF: begin
				state_d = ST_JUDGE;
			end
			ST_JUDGE: begin
				if (pass) begin
					mem_we    = 1'b1;
					mem_wdata = '{kind: item_q.kind, sensor: item_q.sensor_id,
						value: item_q.value, rejects: 8'd0, stamp: now_q};
					state_d   = ST_EMIT;
				end else begin
					// a rejected jump counts, saturating
					if (!reasonable && (ent_q.rejects != REJECTS_MAX)) begin
						mem_we            = 1'b1;
						mem_wdata.rejects = ent_q.rejects + 8'd1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_MISS: begin
				// new key goes to the lowest free slot, which is the fill count
				if (room) begin
					mem_we    = 1'b1;
					mem_waddr = fill_q[AW-1:0];
					mem_wdata = '{kind: item_q.kind, sensor: item_q.sensor_id,
						value: item_q.value, rejects: 8'd0, stamp: now_q};
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			ent_q <= mem[addr_q[AW-1:0]];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chg_q[0] <= RST_MAX_TEMP;
			max_chg_q[1] <= RST_MAX_HUMIDITY;
			max_chg_q[2] <= RST_MAX_RAIN_RATE;
			max_chg_q[3] <= RST_MAX_RAIN_TOTAL;
			refresh_q    <= RST_REFRESH_TICKS;
			rej_limit_q  <= RST_REJECT_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MAX_TEMP:       max_chg_q[0] <= cfg_data[30:0];
				CFG_MAX_HUMIDITY:   max_chg_q[1] <= cfg_data[30:0];
				CFG_MAX_RAIN_RATE:  max_chg_q[2] <= cfg_data[30:0];
				CFG_MAX_RAIN_TOTAL: max_chg_q[3] <= cfg_data[30:0];
				CFG_REFRESH_TICKS:  refresh_q    <= cfg_data;
				CFG_REJECT_LIMIT:   rej_limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			addr_q      <= '0;
			chk_s1      <= 1'b0;
			chk_idx_s1  <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_accept) begin
				now_q <= now_q + 32'd1;
			end
			if (meas_accept) begin
				addr_q <= '0;
			end else if (mem_re) begin
				addr_q <= addr_q + CW'(1);
			end
			chk_s1 <= mem_re;
			if (mem_re) begin
				chk_idx_s1 <= addr_q[AW-1:0];
			end
			if ((state_q == ST_MISS) && room) begin
				fill_q <= fill_q + CW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and arithmetic registers
	always_ff @(posedge clk) begin
		if (meas_accept) begin
			item_q  <= sample.data;
			first_q <= 1'b0;
			full_q  <= 1'b0;
		end
		if (state_q == ST_DIFF) begin
			diff_q    <= {item_q.value[31], item_q.value}
				- {ent_q.value[31], ent_q.value};
			elapsed_q <= now_q - ent_q.stamp;
			changed_q <= item_q.value != ent_q.value;
		end
		if (state_q == ST_MISS) begin
			first_q <= room;
			full_q  <= !room;
		end
		if (load_out) begin
			out_q <= '{out_kind: item_q.kind, out_sensor_id: item_q.sensor_id,
				out_value: item_q.value, first_seen: first_q, table_full: full_q};
		end
	end

	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CW'(ENTRIES))
		else $error("fill count beyond table size");

	// a measurement always starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n) meas_accept |=> state_q == ST_SCAN)
		else $error("measurement did not start a scan");

	// a tick advances the clock by one
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> now_q == $past(now_q) + 32'd1)
		else $error("tick did not advance the clock");

	// a result is never both newly stored and unstored
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.first_seen && out_q.table_full))
		else $error("first_seen and table_full both set");

	// a pending result is not overwritten before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load_out)
		else $error("output register overwritten");

endmodule

[sim/testbench.sv]
module testbench;
	import srcf_pkg::*;

	localparam int unsigned ENTRIES = 64;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 225;
	localparam int unsigned CFG_WRITES = 7;
	// a measurement with no result may still be scanning the whole table
	localparam int unsigned SETTLE_CYCLES = ENTRIES + 16;

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_REJECT_LIMIT + 3'd1;

	localparam logic [1:0] KIND_TEMP       = 2'd0;
	localparam logic [1:0] KIND_HUMIDITY   = 2'd1;
	localparam logic [1:0] KIND_RAIN_RATE  = 2'd2;
	localparam logic [1:0] KIND_RAIN_TOTAL = 2'd3;

	// tracks the filter table and the expected pass-through transactions
	class reading_filter_scoreboard;
		logic [30:0] max_jump [4];
		logic [31:0] refresh_after;
		logic [7:0]  reject_limit;
		bit          slot_used [ENTRIES];
		entry_t      slot [ENTRIES];
		logic [31:0] clock_ms;
		result_t     expected_results [$];
		int unsigned errors;

		function new();
			max_jump[KIND_TEMP] = RST_MAX_TEMP;
			max_jump[KIND_HUMIDITY] = RST_MAX_HUMIDITY;
			max_jump[KIND_RAIN_RATE] = RST_MAX_RAIN_RATE;
			max_jump[KIND_RAIN_TOTAL] = RST_MAX_RAIN_TOTAL;
			refresh_after = RST_REFRESH_TICKS;
			reject_limit = RST_REJECT_LIMIT;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			clock_ms = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MAX_TEMP, CFG_MAX_HUMIDITY, CFG_MAX_RAIN_RATE, CFG_MAX_RAIN_TOTAL: begin
					max_jump[idx[1:0]] = data[30:0];
				end
				CFG_REFRESH_TICKS: begin
					refresh_after = data;
				end
				CFG_REJECT_LIMIT: begin
					reject_limit = data[7:0];
				end
				default: begin
				end
			endcase
		endfunction

		function bit lookup(logic [1:0] kind, logic [15:0] sensor, output logic [31:0] value);
			value = '0;
			foreach (slot_used[i]) begin
				if (slot_used[i] && slot[i].kind == kind && slot[i].sensor == sensor) begin
					value = slot[i].value;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_sample(sample_t s);
			int          hit;
			int          vacant;
			int          i;
			logic signed [32:0] diff;
			logic [32:0] jump;
			logic [31:0] elapsed;
			bit          changed;
			bit          timed;
			bit          reasonable;
			bit          lenient;
			result_t     r;
			hit = -1;
			vacant = -1;
			if (s.command == CMD_TICK) begin
				clock_ms = clock_ms + 32'd1;
				return;
			end
			r.out_kind = s.kind;
			r.out_sensor_id = s.sensor_id;
			r.out_value = s.value;
			r.first_seen = 1'b0;
			r.table_full = 1'b0;
			for (i = 0; i < ENTRIES; i++) begin
				if (slot_used[i]) begin
					if (hit < 0 && slot[i].kind == s.kind && slot[i].sensor == s.sensor_id) begin
						hit = i;
					end
				end else if (vacant < 0) begin
					vacant = i;
				end
			end
			if (hit >= 0) begin
				// exact 33-bit jump, no wrap
				diff = $signed({s.value[31], s.value})
					- $signed({slot[hit].value[31], slot[hit].value});
				jump = diff[32] ? 33'(-diff) : 33'(diff);
				elapsed = clock_ms - slot[hit].stamp;
				changed = s.value != slot[hit].value;
				timed = elapsed > refresh_after;
				reasonable = jump < {2'b00, max_jump[s.kind]};
				lenient = slot[hit].rejects > reject_limit;
				if ((timed || changed) && (reasonable || lenient)) begin
					slot[hit].rejects = '0;
					slot[hit].value = s.value;
					slot[hit].stamp = clock_ms;
					expected_results.push_back(r);
				end else if (!reasonable && slot[hit].rejects != REJECTS_MAX) begin
					slot[hit].rejects = slot[hit].rejects + 8'd1;
				end
			end else if (vacant >= 0) begin
				slot_used[vacant] = 1'b1;
				slot[vacant].kind = s.kind;
				slot[vacant].sensor = s.sensor_id;
				slot[vacant].value = s.value;
				slot[vacant].rejects = '0;
				slot[vacant].stamp = clock_ms;
				r.first_seen = 1'b1;
				expected_results.push_back(r);
			end else begin
				r.table_full = 1'b1;
				expected_results.push_back(r);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: kind %0d sensor 0x%04h value 0x%08h",
					got.out_kind, got.out_sensor_id, got.out_value);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
			check_field("out_sensor_id", 32'(want.out_sensor_id), 32'(got.out_sensor_id));
			check_field("out_value", want.out_value, got.out_value);
			check_field("first_seen", 32'(want.first_seen), 32'(got.first_seen));
			check_field("table_full", 32'(want.table_full), 32'(got.table_full));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           send_idle_pct = 38;
	int unsigned           recv_idle_pct = 60;
	reading_filter_scoreboard sb;

	// register write order per phase, the last one hits no register
	logic [CFG_IDX_W-1:0] reg_order [CFG_WRITES] = '{
		CFG_MAX_TEMP, CFG_MAX_HUMIDITY, CFG_MAX_RAIN_RATE, CFG_MAX_RAIN_TOTAL,
		CFG_REFRESH_TICKS, CFG_REJECT_LIMIT, CFG_UNMAPPED
	};

	// per phase: temp, humidity, rain rate, rain total, refresh, reject limit, junk
	logic [31:0] cfg_plan [PHASES][CFG_WRITES] = '{
		// reset values
		'{32'd2000, 32'd2000, 32'd20000, 32'd20000, 32'd3600000, 32'd18, 32'hFFFF_FFFF},
		// refresh at zero, reject limit zero, oversize value masked to 31 bits
		'{32'd100, 32'd5000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h0000_0000},
		// zero jump limits: only the rejection rule lets readings through
		'{32'd0, 32'd0, 32'd0, 32'd0, 32'd10, 32'd3, 32'h5A5A_5A5A},
		// widest temperature limit, refresh never runs out, count can never exceed limit
		'{32'h7FFF_FFFF, 32'd1, 32'd300, 32'd2000, 32'hFFFF_FFFF, 32'd255, 32'hA5A5_A5A5},
		'{32'd2000, 32'd2000, 32'd20000, 32'd20000, 32'd1, 32'd254, 32'hFFFF_FFFF},
		'{32'd500, 32'd500, 32'd500, 32'd500, 32'd40, 32'd5, 32'h0000_0000}
	};

	srcf_stream_if #(.T(sample_t)) sample_ch ();
	srcf_stream_if #(.T(result_t)) result_ch ();

	sensor_reading_change_filter_unit #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver backpressure, one decision per clock
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// every result transaction is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready) begin
			sb.check_result(result_ch.data);
		end
	end

	function automatic sample_t make_item(logic cmd, logic [1:0] kind, logic [15:0] id,
		logic [31:0] value);
		sample_t s;
		s.command = cmd;
		s.kind = kind;
		s.sensor_id = id;
		s.value = value;
		return s;
	endfunction

	// valid stays high from one transaction to the next unless a gap is drawn
	task automatic send_item(input sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(s);
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain_results(input int unsigned extra);
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic configure(input int unsigned p);
		int i;
		for (i = 0; i < CFG_WRITES; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_order[i];
			cfg_data <= cfg_plan[p][i];
			@(posedge clk);
			sb.write_reg(reg_order[i], cfg_plan[p][i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		sample_t     item;
		logic [17:0] key_pool [48];
		logic [17:0] key;
		logic [31:0] base;
		logic [31:0] lim;
		logic [31:0] d;
		int unsigned sel;
		int unsigned p;
		int unsigned n;

		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;

		// four hot keys take about half of the measurements so rejection counts can build up
		key_pool[0] = {KIND_TEMP, 16'h0000};
		key_pool[1] = {KIND_RAIN_TOTAL, 16'hFFFF};
		key_pool[2] = {KIND_HUMIDITY, 16'h5A5A};
		key_pool[3] = {KIND_RAIN_RATE, 16'hA5A5};
		for (n = 4; n < 48; n++) key_pool[n] = 18'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: value extremes, jump at and below the limit
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h8000_0000));
		// largest possible jump, must not wrap into a small one
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h7FFF_FFFF));
		// unchanged and not timed out: dropped without counting
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h8000_0000));
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h8000_07CF));
		// jump equal to the limit is rejected
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h8000_0F9F));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_TOTAL, 16'hFFFF, 32'h7FFF_FFFF));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_TOTAL, 16'hFFFF, 32'h7FFF_B1E0));
		// same sensor id under another kind is a separate key
		send_item(make_item(CMD_MEASURE, KIND_HUMIDITY, 16'h0000, 32'h0000_0000));
		send_item(make_item(CMD_MEASURE, KIND_HUMIDITY, 16'h0000, 32'hFFFF_F831));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_RATE, 16'h8000, 32'hFFFF_FFFF));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_RATE, 16'h8000, 32'h0000_4E1E));
		send_item(make_item(CMD_TICK, KIND_TEMP, 16'h0000, 32'h0000_0000));
		send_item(make_item(CMD_TICK, KIND_RAIN_TOTAL, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_RATE, 16'h0001, 32'h5555_5555));
		send_item(make_item(CMD_MEASURE, KIND_RAIN_RATE, 16'h0001, 32'hAAAA_AAAA));
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h0000, 32'h8000_0F9F));
		send_item(make_item(CMD_MEASURE, KIND_TEMP, 16'h7FFF, 32'h0000_0000));

		for (p = 0; p < PHASES; p++) begin
			drain_results(SETTLE_CYCLES);
			// receiver-heavy idling, then sender-heavy, then none at all
			if (p == 2) begin
				send_idle_pct = 60;
				recv_idle_pct = 38;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure(p);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(199) == 0) drain_results(0);
				if ($urandom_range(99) < 25) begin
					item = make_item(CMD_TICK, 2'($urandom), 16'($urandom), $urandom);
				end else begin
					sel = $urandom_range(99);
					if (sel < 45) key = key_pool[$urandom_range(3)];
					else if (sel < 96) key = key_pool[$urandom_range(47)];
					else key = 18'($urandom);
					// values relative to the stored one, so jumps land near the limit
					if (!sb.lookup(key[17:16], key[15:0], base)) base = $urandom;
					lim = {1'b0, sb.max_jump[key[17:16]]};
					d = (lim == 0) ? 32'd0 : $urandom % lim;
					sel = $urandom_range(99);
					if (sel < 15) d = 32'd0;
					else if (sel < 58 && sel >= 50) d = lim;
					else if (sel < 63 && sel >= 58) d = (lim == 0) ? 32'd0 : lim - 32'd1;
					else if (sel >= 63) d = $urandom;
					item = make_item(CMD_MEASURE, key[17:16], key[15:0],
						$urandom_range(1) ? base + d : base - d);
					if (sel >= 85 && sel < 93) item.value = $urandom;
					else if (sel >= 93) item.value = $urandom_range(1) ? 32'h7FFF_FFFF
						: 32'h8000_0000;
				end
				send_item(item);
			end
		end

		drain_results(SETTLE_CYCLES);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
